@@ hdl/ats_pkg.sv @@
// ----------------------------------------------------------------------------
// ats_pkg
// Shared types, codes and fixed widths of the transition offset smoother.
// ----------------------------------------------------------------------------
package ats_pkg;

    localparam int AXIS_SLOTS_DEF      = 32;
    localparam int VALUE_FRAC_BITS_DEF = 14;

    // stream payload layout
    localparam int S_TDATA_W = 128;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 24;

    localparam int AX_W   = 5;
    localparam int IN_W   = 16;
    localparam int SRC_W  = 7;
    localparam int TIME_W = 64;

    localparam int AX_LSB   = 0;
    localparam int ACT_LSB  = AX_LSB + AX_W;
    localparam int MAP_LSB  = ACT_LSB + IN_W;
    localparam int CUR_LSB  = MAP_LSB + IN_W;
    localparam int SRC_LSB  = CUR_LSB + IN_W;
    localparam int TIME_LSB = SRC_LSB + SRC_W;
    localparam int PAY_W    = TIME_LSB + TIME_W;

    // timing arithmetic
    localparam int DUR_W = 26;
    localparam int Q_W   = 16;
    localparam logic [DUR_W-1:0] MS_TO_US = DUR_W'(1000);
    localparam logic [Q_W+1:0]   SMOOTH_K = (Q_W+2)'(3 * 65536);
    localparam logic [Q_W:0]     UNITY_Q  = (Q_W+1)'(65536);

    // shared multiplier
    localparam int MA_W   = 33;
    localparam int MB_W   = 19;
    localparam int PROD_W = MA_W + MB_W;
    localparam int SUM_W  = PROD_W - Q_W + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [2:0] {
        OP_APPLY      = 3'd0,
        OP_BEGIN      = 3'd1,
        OP_CLEAR_AXIS = 3'd2,
        OP_CLEAR_ALL  = 3'd3,
        OP_QUERY      = 3'd4
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMOOTH_EN = 2'd0,
        CFG_DUR_MS    = 2'd1,
        CFG_JUMP_THR  = 2'd2,
        CFG_INTENT    = 2'd3
    } t_cfg_idx;

    localparam logic [15:0] JUMP_THR_RST = 16'd164;
    localparam logic [15:0] INTENT_RST   = 16'd1638;

endpackage

@@ hdl/ats_ram.sv @@
// ----------------------------------------------------------------------------
// ats_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ats_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/ats_div.sv @@
// ----------------------------------------------------------------------------
// ats_div
// Restoring divider, one quotient bit per cycle: floor(a * 2^16 / d), a < d.
// ----------------------------------------------------------------------------
module ats_div
    import ats_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DUR_W-1:0] i_dividend,
    input  logic [DUR_W-1:0] i_divisor,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(Q_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DUR_W-1:0] r_rem;
    logic [DUR_W-1:0] r_div;
    logic [Q_W-1:0]   r_quot;

    logic [DUR_W:0]   w_shift;
    logic [DUR_W:0]   w_diff;
    logic             w_ge;

    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = w_shift >= {1'b0, r_div};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_dividend;
                r_div  <= i_divisor;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[DUR_W-1:0] : w_shift[DUR_W-1:0];
                r_quot <= {r_quot[Q_W-2:0], w_ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ hdl/axis_transition_offset_smoother.sv @@
// ----------------------------------------------------------------------------
// axis_transition_offset_smoother
// Per-axis smoothstep crossfade of output jumps after a mapping change.
// ----------------------------------------------------------------------------
// One item is handled at a time and the input is not ready until its result
// has been placed in the output register. Every transfer passes through the
// decode and done steps; a begin on a valid axis adds the begin step, and an
// apply on an active slot adds the check step, then the expire step when not
// cancelled. An apply on an active, unexpired slot then runs the 16-step
// restoring divider for elapsed/duration and makes three passes through the
// one shared 33x19 multiplier (p*p, the smoothstep cubic and the offset
// scaling) before the sum step. A result left waiting holds the block in its
// last step. Results queue in a one-deep output register, so the next transfer
// is accepted while a result still waits. Slot payload lives in a RAM; only the
// active flags are flip-flops, cleared by reset and clear-all.
module axis_transition_offset_smoother
    import ats_pkg::*;
#(
    parameter int AXIS_SLOTS      = AXIS_SLOTS_DEF,
    parameter int VALUE_FRAC_BITS = VALUE_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // axis_index, actual_output, mapped_output, current_input, source_axis, now_us
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // op
    input  logic [S_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // axis_value, slot_active
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SLOT_W = $clog2(AXIS_SLOTS);
    localparam int VAL_W  = VALUE_FRAC_BITS + 2;
    localparam int OFF_W  = VAL_W + 1;
    localparam logic signed [SUM_W-1:0]  ONE_S   = SUM_W'(1) << VALUE_FRAC_BITS;
    localparam logic signed [VAL_W-1:0]  ONE_V   = VAL_W'(1) << VALUE_FRAC_BITS;
    localparam logic signed [PROD_W-1:0] ROUND_P = PROD_W'(32768);

    typedef struct packed {
        logic signed [OFF_W-1:0] off;
        logic signed [IN_W-1:0]  in_sw;
        logic signed [SRC_W-1:0] src;
        logic [TIME_W-1:0]       start;
        logic [DUR_W-1:0]        dur;
    } t_slot;

    localparam int SLOT_DW = $bits(t_slot);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_BEGIN,
        S_CHECK,
        S_EXPIRE,
        S_DIV,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_SUM,
        S_DONE
    } t_state;

    function automatic logic signed [VAL_W-1:0] f_clamp(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        c = v;
        if (v > ONE_S) c = ONE_S;
        if (v < -ONE_S) c = -ONE_S;
        return VAL_W'(c);
    endfunction

    t_state r_state;

    logic                    r_smooth_en;
    logic [15:0]             r_dur_ms;
    logic [15:0]             r_jump_thr;
    logic [15:0]             r_intent;

    t_op                     r_op;
    logic [AX_W-1:0]         r_ax;
    logic signed [IN_W-1:0]  r_actual;
    logic signed [IN_W-1:0]  r_mapped;
    logic signed [IN_W-1:0]  r_cur;
    logic signed [SRC_W-1:0] r_src;
    logic [TIME_W-1:0]       r_now;

    logic [AXIS_SLOTS-1:0]   r_flags;
    logic signed [OFF_W-1:0] r_off;
    logic [DUR_W-1:0]        r_dur;
    logic [TIME_W-1:0]       r_elapsed;
    logic [Q_W-1:0]          r_p;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [VAL_W-1:0] r_result;
    logic                    r_div_start;

    logic                    r_out_valid;
    logic signed [IN_W-1:0]  r_out_value;
    logic                    r_out_active;

    logic                    w_s_accept;
    logic [SLOT_W-1:0]       w_addr;
    logic                    w_in_range;
    logic                    w_valid;
    logic signed [VAL_W-1:0] w_map_c;
    logic signed [VAL_W-1:0] w_act_c;
    logic signed [OFF_W-1:0] w_off;
    logic [OFF_W-1:0]        w_mag;
    logic [DUR_W-1:0]        w_dur_us;
    logic                    w_arm;
    t_slot                   w_wslot;
    t_slot                   w_rslot;
    logic [SLOT_DW-1:0]      w_rdata;
    logic signed [IN_W:0]    w_idiff;
    logic [IN_W:0]           w_iabs;
    logic                    w_cancel;
    logic [TIME_W-1:0]       w_elapsed;
    logic                    w_div_done;
    logic [Q_W-1:0]          w_quot;
    logic [Q_W+1:0]          w_cubic;
    logic [Q_W:0]            w_decay;
    logic signed [MA_W-1:0]  w_mul_a;
    logic signed [MB_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_rnd;
    logic signed [SUM_W-1:0] w_corr;
    logic signed [SUM_W-1:0] w_sum;
    logic                    w_ram_we;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_s_accept      = i_s_axis_tvalid && o_s_axis_tready;

    assign w_addr     = SLOT_W'(r_ax);
    assign w_in_range = 32'(r_ax) < AXIS_SLOTS;
    assign w_valid    = (r_ax != '0) && w_in_range;

    // begin path
    assign w_map_c  = f_clamp(SUM_W'(r_mapped));
    assign w_act_c  = f_clamp(SUM_W'(r_actual));
    assign w_off    = OFF_W'(w_act_c) - OFF_W'(w_map_c);
    assign w_mag    = w_off[OFF_W-1] ? OFF_W'(-w_off) : OFF_W'(w_off);
    assign w_dur_us = DUR_W'(r_dur_ms) * MS_TO_US;
    assign w_arm    = r_smooth_en && (r_dur_ms != '0) && (32'(w_mag) >= 32'(r_jump_thr));

    assign w_wslot.off   = w_off;
    assign w_wslot.in_sw = r_cur;
    assign w_wslot.src   = r_src;
    assign w_wslot.start = r_now;
    assign w_wslot.dur   = w_dur_us;
    assign w_ram_we      = (r_state == S_BEGIN) && w_arm;

    ats_ram #(
        .WIDTH (SLOT_DW),
        .DEPTH (AXIS_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_addr),
        .i_wdata (w_wslot),
        .i_re    (r_state == S_DECODE),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    assign w_rslot = w_rdata;

    // apply checks
    assign w_idiff   = (IN_W+1)'(r_cur) - (IN_W+1)'(w_rslot.in_sw);
    assign w_iabs    = w_idiff[IN_W] ? (IN_W+1)'(-w_idiff) : (IN_W+1)'(w_idiff);
    assign w_cancel  = (w_rslot.src != r_src)
                    || (!r_src[SRC_W-1] && (w_iabs >= (IN_W+1)'(r_intent)));
    assign w_elapsed = (r_now >= w_rslot.start) ? r_now - w_rslot.start : '0;

    ats_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_elapsed[DUR_W-1:0]),
        .i_divisor  (r_dur),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // shared multiplier
    assign w_cubic = SMOOTH_K - {1'b0, r_p, 1'b0};
    assign w_decay = UNITY_Q - r_prod[2*Q_W+Q_W:2*Q_W];

    always_comb begin
        case (r_state)
            S_MUL2: begin
                w_mul_a = MA_W'(r_prod[2*Q_W-1:0]);
                w_mul_b = MB_W'(w_cubic);
            end
            S_MUL3: begin
                w_mul_a = MA_W'(r_off);
                w_mul_b = MB_W'(w_decay);
            end
            default: begin
                w_mul_a = MA_W'(r_p);
                w_mul_b = MB_W'(r_p);
            end
        endcase
    end

    assign w_rnd  = r_prod + ROUND_P;
    assign w_corr = SUM_W'(w_rnd >>> Q_W);
    assign w_sum  = w_corr + SUM_W'(w_map_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_smooth_en  <= 1'b0;
            r_dur_ms     <= '0;
            r_jump_thr   <= JUMP_THR_RST;
            r_intent     <= INTENT_RST;
            r_flags      <= '0;
            r_div_start  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_div_start <= 1'b0;

            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SMOOTH_EN: r_smooth_en <= i_cfg_data[0];
                    CFG_DUR_MS:    r_dur_ms    <= i_cfg_data;
                    CFG_JUMP_THR:  r_jump_thr  <= i_cfg_data;
                    CFG_INTENT:    r_intent    <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_s_accept) begin
                        r_op     <= t_op'(i_s_axis_tuser);
                        r_ax     <= i_s_axis_tdata[AX_LSB +: AX_W];
                        r_actual <= i_s_axis_tdata[ACT_LSB +: IN_W];
                        r_mapped <= i_s_axis_tdata[MAP_LSB +: IN_W];
                        r_cur    <= i_s_axis_tdata[CUR_LSB +: IN_W];
                        r_src    <= i_s_axis_tdata[SRC_LSB +: SRC_W];
                        r_now    <= i_s_axis_tdata[TIME_LSB +: TIME_W];
                        r_state  <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_result <= '0;
                    r_state  <= S_DONE;
                    case (r_op)
                        OP_APPLY: begin
                            r_result <= w_map_c;
                            if (w_valid && r_flags[w_addr]) begin
                                r_state <= S_CHECK;
                            end
                        end
                        OP_BEGIN: begin
                            if (w_valid) begin
                                r_state <= S_BEGIN;
                            end
                        end
                        OP_CLEAR_AXIS: begin
                            if (w_in_range) begin
                                r_flags[w_addr] <= 1'b0;
                            end
                        end
                        OP_CLEAR_ALL: begin
                            r_flags <= '0;
                        end
                        default: ;
                    endcase
                end
                S_BEGIN: begin
                    r_flags[w_addr] <= w_arm;
                    r_state         <= S_DONE;
                end
                S_CHECK: begin
                    r_off     <= w_rslot.off;
                    r_dur     <= w_rslot.dur;
                    r_elapsed <= w_elapsed;
                    if (w_cancel) begin
                        r_flags[w_addr] <= 1'b0;
                        r_state         <= S_DONE;
                    end else begin
                        r_state <= S_EXPIRE;
                    end
                end
                S_EXPIRE: begin
                    if ((r_dur == '0) || (r_elapsed >= TIME_W'(r_dur))) begin
                        r_flags[w_addr] <= 1'b0;
                        r_state         <= S_DONE;
                    end else begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_p     <= w_quot;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_prod  <= w_mul_a * w_mul_b;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_prod  <= w_mul_a * w_mul_b;
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_prod  <= w_mul_a * w_mul_b;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_result <= f_clamp(w_sum);
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= IN_W'(r_result);
                        r_out_active <= w_valid && r_flags[w_addr];
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(M_TDATA_W-IN_W-1)'(0), r_out_active, r_out_value};

`ifndef SYNTHESIS
    a_slot0_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_flags[0])
        else $error("slot 0 became active");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_accept |=> (r_state == S_DECODE))
        else $error("accepted transfer not decoded");

    a_div_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its step");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> ((r_result <= ONE_V) && (r_result >= -ONE_V)))
        else $error("result outside unit range");
`endif

endmodule

@@ bench/axis_transition_offset_smoother_tb.sv @@
// ----------------------------------------------------------------------------
// axis_transition_offset_smoother_tb
// Self-checking bench for the transition offset smoother. A directed run
// covers the slot corner cases, then several register settings are each
// followed by random streams of begin/apply sequences mixed with clears,
// queries and noise. A scoreboard class predicts every result in order and
// compares it field by field. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module axis_transition_offset_smoother_tb;
    import ats_pkg::*;

    localparam int ONE_Q        = 1 << VALUE_FRAC_BITS_DEF;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_LONG    = 400;
    localparam int PHASE_ITEMS  = 250;

    typedef struct {
        logic [2:0]              op;
        logic [AX_W-1:0]         ax;
        logic signed [IN_W-1:0]  actual;
        logic signed [IN_W-1:0]  mapped;
        logic signed [IN_W-1:0]  cur;
        logic signed [SRC_W-1:0] src;
        logic [TIME_W-1:0]       now;
    } op_item_t;

    typedef struct {
        logic [15:0] value;
        logic        active;
    } slot_result_t;

    typedef struct {
        logic        en;
        logic [15:0] dur;
        logic [15:0] thr;
        logic [15:0] intent;
    } cfg_set_t;

    class smoother_board;
        logic            en;
        logic [15:0]     dur_ms;
        logic [15:0]     thr;
        logic [15:0]     intent;
        bit              live    [AXIS_SLOTS_DEF];
        int              offs    [AXIS_SLOTS_DEF];
        int              in_sw   [AXIS_SLOTS_DEF];
        int              src_sw  [AXIS_SLOTS_DEF];
        longint unsigned t0      [AXIS_SLOTS_DEF];
        longint unsigned span_us [AXIS_SLOTS_DEF];
        slot_result_t    pending_results[$];
        int              errors;

        function new();
            en     = 1'b0;
            dur_ms = '0;
            thr    = JUMP_THR_RST;
            intent = INTENT_RST;
            errors = 0;
            for (int i = 0; i < AXIS_SLOTS_DEF; i++) drop_slot(i);
        endfunction

        function void set_reg(t_cfg_idx idx, logic [15:0] d);
            case (idx)
                CFG_SMOOTH_EN: en     = d[0];
                CFG_DUR_MS:    dur_ms = d;
                CFG_JUMP_THR:  thr    = d;
                CFG_INTENT:    intent = d;
                default: ;
            endcase
        endfunction

        function int clamp_q(longint v);
            if (v > ONE_Q) return ONE_Q;
            if (v < -ONE_Q) return -ONE_Q;
            return int'(v);
        endfunction

        function void drop_slot(int ax);
            live[ax]    = 1'b0;
            offs[ax]    = 0;
            in_sw[ax]   = 0;
            src_sw[ax]  = 0;
            t0[ax]      = 0;
            span_us[ax] = 0;
        endfunction

        function int smoothed_value(int ax, bit ok, int mapped, int cur, int src,
                                    longint unsigned now);
            longint unsigned elapsed;
            longint unsigned p;
            longint unsigned s;
            longint          corr;
            int              diff;
            if (!ok || !live[ax]) return mapped;
            diff = cur - in_sw[ax];
            if (diff < 0) diff = -diff;
            if (src_sw[ax] != src || (src >= 0 && diff >= int'(intent))) begin
                drop_slot(ax);
                return mapped;
            end
            elapsed = (now >= t0[ax]) ? now - t0[ax] : 64'd0;
            if (span_us[ax] == 0 || elapsed >= span_us[ax]) begin
                drop_slot(ax);
                return mapped;
            end
            p    = (elapsed << 16) / span_us[ax];
            s    = (p * p * (64'd196608 - 2 * p)) >> 32;
            corr = longint'(offs[ax]) * longint'(64'd65536 - s);
            corr = (corr + 32768) >>> 16;
            return clamp_q(longint'(mapped) + corr);
        endfunction

        function void arm_slot(int ax, bit ok, int actual, int mapped, int cur, int src,
                               longint unsigned now);
            int off;
            int mag;
            if (!ok) return;
            if (!en || dur_ms == 0) begin
                drop_slot(ax);
                return;
            end
            off = clamp_q(actual) - mapped;
            mag = (off < 0) ? -off : off;
            if (mag < int'(thr)) begin
                drop_slot(ax);
                return;
            end
            live[ax]    = 1'b1;
            offs[ax]    = off;
            in_sw[ax]   = cur;
            src_sw[ax]  = src;
            t0[ax]      = now;
            span_us[ax] = longint'(dur_ms) * 1000;
        endfunction

        function void note_input(op_item_t it);
            int           ax;
            bit           ok;
            int           mapped;
            int           value;
            slot_result_t r;
            ax     = int'(it.ax);
            ok     = ax > 0 && ax < AXIS_SLOTS_DEF;
            mapped = clamp_q(longint'(it.mapped));
            value  = 0;
            case (it.op)
                OP_APPLY:
                    value = smoothed_value(ax, ok, mapped, it.cur, it.src, it.now);
                OP_BEGIN:
                    arm_slot(ax, ok, it.actual, mapped, it.cur, it.src, it.now);
                OP_CLEAR_AXIS:
                    if (ax < AXIS_SLOTS_DEF) drop_slot(ax);
                OP_CLEAR_ALL:
                    for (int i = 0; i < AXIS_SLOTS_DEF; i++) drop_slot(i);
                default: ;
            endcase
            r.value  = 16'(value);
            r.active = ok && live[ax];
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] d);
            slot_result_t e;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual value %0d active %0b",
                         $time, $signed(d[15:0]), d[16]);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (d[15:0] !== e.value) begin
                $display("%0t: axis_value mismatch, expected %0d, actual %0d",
                         $time, $signed(e.value), $signed(d[15:0]));
                errors++;
            end
            if (d[16] !== e.active) begin
                $display("%0t: slot_active mismatch, expected %0b, actual %0b",
                         $time, e.active, d[16]);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    smoother_board   board = new();
    op_item_t        stim_q[$];
    bit              src_steady = 1'b0;
    bit              sink_steady = 1'b0;
    bit              pressure_req = 1'b0;
    logic [15:0]     cur_dur_ms = '0;
    longint unsigned clock_us = 64'd1000000;
    int              held_in  [AXIS_SLOTS_DEF];
    int              held_src [AXIS_SLOTS_DEF];

    axis_transition_offset_smoother dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin : clock_gen
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [15:0] rand_q();
        if ($urandom_range(0, 9) < 7) return 16'($urandom_range(0, 32768) - 16384);
        return 16'($urandom);
    endfunction

    function automatic op_item_t mk(logic [2:0] op, int ax, int actual, int mapped,
                                    int cur, int src, longint unsigned now);
        op_item_t it;
        it.op     = op;
        it.ax     = AX_W'(ax);
        it.actual = 16'(actual);
        it.mapped = 16'(mapped);
        it.cur    = 16'(cur);
        it.src    = 7'(src);
        it.now    = now;
        return it;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_item(op_item_t it);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[AX_LSB +: AX_W]     = it.ax;
        d[ACT_LSB +: IN_W]    = it.actual;
        d[MAP_LSB +: IN_W]    = it.mapped;
        d[CUR_LSB +: IN_W]    = it.cur;
        d[SRC_LSB +: SRC_W]   = it.src;
        d[TIME_LSB +: TIME_W] = it.now;
        return d;
    endfunction

    // mostly begin/apply sequences on a few axes with a running clock
    function automatic op_item_t random_item();
        op_item_t        it;
        int              pick;
        int              ax;
        int              delta;
        longint unsigned span;
        span = (cur_dur_ms == 0) ? 64'd1000 : longint'(cur_dur_ms) * 1000;
        pick = $urandom_range(0, 99);
        ax   = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(0, 31);
        case ($urandom_range(0, 19))
            0:       it.now = clock_us - $urandom_range(0, 32'(span));
            1: begin
                clock_us += span * 2;
                it.now = clock_us;
            end
            default: begin
                clock_us += $urandom_range(0, 32'(span / 6));
                it.now = clock_us;
            end
        endcase
        delta = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8000) - 4000
                                            : $urandom_range(0, 600) - 300;
        it.ax     = AX_W'(ax);
        it.actual = rand_q();
        it.mapped = rand_q();
        it.cur    = 16'(held_in[ax] + delta);
        it.src    = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 63) - 1)
                                                : 7'(held_src[ax]);
        if (pick < 45) begin
            it.op = OP_APPLY;
        end else if (pick < 70) begin
            it.op = OP_BEGIN;
            if ($urandom_range(0, 4) == 0) begin
                it.actual = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
                it.mapped = (it.actual < 0) ? 16'sd16384 : -16'sd16384;
            end
            it.cur        = rand_q();
            it.src        = 7'($urandom_range(0, 63) - 1);
            held_in[ax]   = it.cur;
            held_src[ax]  = it.src;
        end else if (pick < 77) begin
            it.op = OP_CLEAR_AXIS;
            it.ax = AX_W'($urandom_range(0, 31));
        end else if (pick < 79) begin
            it.op = OP_CLEAR_ALL;
        end else if (pick < 87) begin
            it.op = OP_QUERY;
        end else if (pick < 89) begin
            it.op = 3'(OP_QUERY + $urandom_range(1, 3));
        end else begin
            it.op     = 3'($urandom);
            it.ax     = AX_W'($urandom);
            it.actual = 16'($urandom);
            it.mapped = 16'($urandom);
            it.cur    = 16'($urandom);
            it.src    = 7'($urandom);
            it.now    = {$urandom, $urandom};
        end
        return it;
    endfunction

    task automatic run_stim();
        op_item_t it;
        int       gap;
        while (stim_q.size() != 0) begin
            it = stim_q.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= pack_item(it);
            s_tuser  <= it.op;
            do @(posedge clk); while (!s_tready);
            board.note_input(it);
            gap = src_steady ? 0 : pick_gap();
            if (stim_q.size() == 0 || gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic cfg_push(t_cfg_idx idx, logic [15:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, d);
    endtask

    task automatic set_config(cfg_set_t c);
        cfg_push(CFG_SMOOTH_EN, {15'd0, c.en});
        cfg_push(CFG_DUR_MS, c.dur);
        cfg_push(CFG_JUMP_THR, c.thr);
        cfg_push(CFG_INTENT, c.intent);
        cfg_valid  <= 1'b0;
        cur_dur_ms = c.dur;
    endtask

    task automatic wait_drained(int settle);
        while (board.pending_results.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    initial begin : result_sink
        int hold_left;
        int cyc;
        hold_left = 0;
        cyc       = 0;
        forever begin
            @(posedge clk);
            cyc++;
            if (rst_n && m_tvalid === 1'b1 && m_tready) board.check_result(m_tdata);
            if (cyc % 200 == 0) sink_steady = ($urandom_range(0, 3) == 0);
            if (hold_left == 0) begin
                if (pressure_req) begin
                    pressure_req = 1'b0;
                    hold_left    = HOLD_LONG;
                end else if (!sink_steady && $urandom_range(0, 99) < 30) begin
                    hold_left = pick_gap();
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : main
        cfg_set_t        plan[$];
        cfg_set_t        c;
        longint unsigned t_hi;
        t_hi = 64'hFFFF_FFFF_FFFF_0000;
        foreach (held_in[i]) begin
            held_in[i]  = 0;
            held_src[i] = -1;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        c = '{1'b1, 16'd10, 16'd164, 16'd1638};
        set_config(c);
        stim_q.push_back(mk(OP_QUERY, 5, 0, 0, 0, -1, 0));
        stim_q.push_back(mk(OP_BEGIN, 5, 16384, -16384, 0, 3, 1000));
        stim_q.push_back(mk(OP_APPLY, 5, 0, -16384, 0, 3, 1000));
        stim_q.push_back(mk(OP_APPLY, 5, 0, -16384, 100, 3, 6000));
        // source change cancels
        stim_q.push_back(mk(OP_APPLY, 5, 0, 0, 0, 4, 6500));
        stim_q.push_back(mk(OP_BEGIN, 7, 32767, -32768, -32768, -1, t_hi));
        // clock behind start, big input move ignored without a source
        stim_q.push_back(mk(OP_APPLY, 7, 0, 32767, 32767, -1, t_hi - 50));
        stim_q.push_back(mk(OP_APPLY, 7, 0, -32768, 0, -1, t_hi + 9999));
        stim_q.push_back(mk(OP_APPLY, 7, 0, 0, 0, -1, 64'hFFFF_FFFF_FFFF_FFFF));
        stim_q.push_back(mk(OP_BEGIN, 9, 100, 0, 0, 0, 0));
        stim_q.push_back(mk(OP_QUERY, 9, 0, 0, 0, 0, 0));
        stim_q.push_back(mk(OP_BEGIN, 0, 16384, -16384, 0, 0, 0));
        stim_q.push_back(mk(OP_APPLY, 0, 0, -32768, 0, 0, 0));
        stim_q.push_back(mk(OP_BEGIN, 31, -32768, 16384, 1000, 62, 0));
        stim_q.push_back(mk(OP_APPLY, 31, 0, 16384, 2638, 62, 10));
        stim_q.push_back(mk(OP_BEGIN, 12, 8000, 0, 0, 1, 0));
        stim_q.push_back(mk(OP_CLEAR_AXIS, 12, 0, 0, 0, 0, 0));
        stim_q.push_back(mk(OP_QUERY, 12, 0, 0, 0, 0, 0));
        stim_q.push_back(mk(OP_BEGIN, 13, -8000, 0, 0, 2, 0));
        stim_q.push_back(mk(OP_BEGIN, 14, 8000, -8000, 0, 2, 0));
        stim_q.push_back(mk(OP_CLEAR_ALL, 0, 0, 0, 0, 0, 0));
        stim_q.push_back(mk(OP_QUERY, 14, 0, 0, 0, 0, 0));
        stim_q.push_back(mk(OP_CLEAR_AXIS, 0, 0, 0, 0, 0, 0));
        for (int k = 1; k <= 3; k++)
            stim_q.push_back(mk(3'(OP_QUERY + k), 1, 0, 0, 0, 0, 0));
        run_stim();

        plan.push_back('{1'b1, 16'd10, 16'd164, 16'd1638});
        plan.push_back('{1'b1, 16'd1, 16'd0, 16'd0});
        plan.push_back('{1'b1, 16'd65535, 16'd32768, 16'd32768});
        plan.push_back('{1'b0, 16'd20, 16'd164, 16'd1638});
        plan.push_back('{1'b1, 16'd0, 16'd100, 16'd1000});
        plan.push_back('{1'b1, 16'($urandom_range(1, 200)), 16'($urandom_range(0, 2000)),
                         16'($urandom_range(0, 4000))});
        plan.push_back('{1'b1, 16'd50, 16'd500, 16'd32768});
        foreach (plan[k]) begin
            wait_drained(4);
            set_config(plan[k]);
            if (k == 0 || k == 3) pressure_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0) src_steady = ($urandom_range(0, 3) == 0);
                stim_q.push_back(random_item());
            end
            run_stim();
        end

        wait_drained(40);
        if (board.errors == 0 && board.pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
